### hw/rtl/rqi_pkg.sv
// ----------------------------------------------------------------------------
// rqi_pkg
// Shared widths, register codes, quad side table and stage structs for the
// ray / quad intersection pipeline.
// ----------------------------------------------------------------------------
package rqi_pkg;

  localparam int CW    = 16;            // coordinate width
  localparam int DW    = CW + 1;        // coordinate difference
  localparam int PW    = 2 * DW;        // product of two differences
  localparam int NW    = PW + 1;        // plane normal component
  localparam int PNW   = NW + DW;       // normal * (v0 - origin)
  localparam int PDW   = NW + CW;       // normal * dir
  localparam int NUMW  = PNW + 2;       // numerator of t
  localparam int DENW  = PDW + 2;       // denominator of t
  localparam int PRW   = NUMW + CW;     // dir * numerator
  localparam int QW    = DW;            // quotient bits kept before saturation
  localparam int SW    = QW + 3;        // origin + quotient before clamping
  localparam int DTW   = PW + 2;        // dot product of differences
  localparam int BW    = 2 * DTW + 1;   // barycentric numerator / denominator
  localparam int NSIDE = 6;
  localparam int NVTX  = 4;
  localparam int VW    = 3 * CW;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_VERTEX_ZERO,
    CFG_VERTEX_ONE,
    CFG_VERTEX_TWO,
    CFG_VERTEX_THREE
  } cfg_idx_e;

  // Per side of the two triangles (v0,v1,v2) and (v0,v2,v3):
  // e = vtx[EP] - vtx[EM], f = vtx[FP] - vtx[FM], r = p - vtx[RB]
  localparam logic [1:0] SIDE_EP [NSIDE] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd3, 2'd0};
  localparam logic [1:0] SIDE_EM [NSIDE] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
  localparam logic [1:0] SIDE_FP [NSIDE] = '{2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd2};
  localparam logic [1:0] SIDE_FM [NSIDE] = '{2'd2, 2'd0, 2'd0, 2'd3, 2'd0, 2'd0};
  localparam logic [1:0] SIDE_RB [NSIDE] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

  typedef struct packed {
    logic [NVTX-1:0][2:0][CW-1:0]   vtx;
    logic [2:0][NW-1:0]             nrm;
    logic [NSIDE-1:0][2:0][DW-1:0]  ev;
    logic [NSIDE-1:0][2:0][DW-1:0]  fv;
    logic [NSIDE-1:0][DTW-1:0]      ff;
    logic [NSIDE-1:0][DTW-1:0]      ef;
    logic [NSIDE-1:0][BW-1:0]       dd;
  } geom_t;

  typedef struct packed {
    logic [2:0][CW-1:0]   org;
    logic                 cand;
    logic [DENW-1:0]      den;
    logic [2:0]           neg;
    logic [2:0]           ovf;
    logic [2:0][DENW-1:0] rem;
    logic [2:0][QW-1:0]   low;
    logic [2:0][QW-1:0]   quo;
  } div_t;

  function automatic logic signed [DW-1:0] cdiff(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
    return DW'($signed(a)) - DW'($signed(b));
  endfunction

endpackage

### hw/rtl/rqi_cfg.sv
// ----------------------------------------------------------------------------
// rqi_cfg
// Quad corner registers and the geometry derived from them: plane normal,
// side edges, edge dot products and barycentric denominators.
// ----------------------------------------------------------------------------
module rqi_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [rqi_pkg::VW-1:0] cfg_data_i,
  output rqi_pkg::geom_t         geom_o
);
  import rqi_pkg::*;

  logic [NVTX-1:0][VW-1:0] vtx_q;
  logic signed [CW-1:0]    vc [NVTX][3];
  logic signed [DW-1:0]    u [3];
  logic signed [DW-1:0]    w [3];
  logic signed [NW-1:0]    nrm_d [3];
  logic signed [NW-1:0]    nrm_q [3];
  logic signed [DW-1:0]    ev_d [NSIDE][3];
  logic signed [DW-1:0]    ev_q [NSIDE][3];
  logic signed [DW-1:0]    fv_d [NSIDE][3];
  logic signed [DW-1:0]    fv_q [NSIDE][3];
  logic signed [PW-1:0]    eep_q [NSIDE][3];
  logic signed [PW-1:0]    ffp_q [NSIDE][3];
  logic signed [PW-1:0]    efp_q [NSIDE][3];
  logic signed [DTW-1:0]   ee_q [NSIDE];
  logic signed [DTW-1:0]   ff_q [NSIDE];
  logic signed [DTW-1:0]   ef_q [NSIDE];
  logic signed [BW-1:0]    pa_q [NSIDE];
  logic signed [BW-1:0]    pb_q [NSIDE];
  logic signed [BW-1:0]    dd_q [NSIDE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VERTEX_ZERO:  vtx_q[0] <= cfg_data_i;
        CFG_VERTEX_ONE:   vtx_q[1] <= cfg_data_i;
        CFG_VERTEX_TWO:   vtx_q[2] <= cfg_data_i;
        CFG_VERTEX_THREE: vtx_q[3] <= cfg_data_i;
        default:          vtx_q    <= vtx_q;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NVTX; i++) begin
      for (int k = 0; k < 3; k++) begin
        vc[i][k] = $signed(vtx_q[i][k*CW +: CW]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      u[k] = cdiff(vc[1][k], vc[0][k]);
      w[k] = cdiff(vc[3][k], vc[0][k]);
    end
    nrm_d[0] = NW'(u[1]) * NW'(w[2]) - NW'(u[2]) * NW'(w[1]);
    nrm_d[1] = NW'(u[2]) * NW'(w[0]) - NW'(u[0]) * NW'(w[2]);
    nrm_d[2] = NW'(u[0]) * NW'(w[1]) - NW'(u[1]) * NW'(w[0]);
    for (int s = 0; s < NSIDE; s++) begin
      for (int k = 0; k < 3; k++) begin
        ev_d[s][k] = cdiff(vc[SIDE_EP[s]][k], vc[SIDE_EM[s]][k]);
        fv_d[s][k] = cdiff(vc[SIDE_FP[s]][k], vc[SIDE_FM[s]][k]);
      end
    end
  end

  // Free-running derivation chain; it settles after each corner write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= '{default: '0};
      ev_q  <= '{default: '0};
      fv_q  <= '{default: '0};
      eep_q <= '{default: '0};
      ffp_q <= '{default: '0};
      efp_q <= '{default: '0};
      ee_q  <= '{default: '0};
      ff_q  <= '{default: '0};
      ef_q  <= '{default: '0};
      pa_q  <= '{default: '0};
      pb_q  <= '{default: '0};
      dd_q  <= '{default: '0};
    end else begin
      nrm_q <= nrm_d;
      ev_q  <= ev_d;
      fv_q  <= fv_d;
      for (int s = 0; s < NSIDE; s++) begin
        for (int k = 0; k < 3; k++) begin
          eep_q[s][k] <= PW'(ev_q[s][k]) * PW'(ev_q[s][k]);
          ffp_q[s][k] <= PW'(fv_q[s][k]) * PW'(fv_q[s][k]);
          efp_q[s][k] <= PW'(ev_q[s][k]) * PW'(fv_q[s][k]);
        end
        ee_q[s] <= DTW'(eep_q[s][0]) + DTW'(eep_q[s][1]) + DTW'(eep_q[s][2]);
        ff_q[s] <= DTW'(ffp_q[s][0]) + DTW'(ffp_q[s][1]) + DTW'(ffp_q[s][2]);
        ef_q[s] <= DTW'(efp_q[s][0]) + DTW'(efp_q[s][1]) + DTW'(efp_q[s][2]);
        pa_q[s] <= BW'(ee_q[s]) * BW'(ff_q[s]);
        pb_q[s] <= BW'(ef_q[s]) * BW'(ef_q[s]);
        dd_q[s] <= pa_q[s] - pb_q[s];
      end
    end
  end

  always_comb begin
    geom_o.vtx = vtx_q;
    for (int k = 0; k < 3; k++) begin
      geom_o.nrm[k] = nrm_q[k];
    end
    for (int s = 0; s < NSIDE; s++) begin
      for (int k = 0; k < 3; k++) begin
        geom_o.ev[s][k] = ev_q[s][k];
        geom_o.fv[s][k] = fv_q[s][k];
      end
      geom_o.ff[s] = ff_q[s];
      geom_o.ef[s] = ef_q[s];
      geom_o.dd[s] = dd_q[s];
    end
  end

endmodule

### hw/rtl/rqi_plane.sv
// ----------------------------------------------------------------------------
// rqi_plane
// Plane distance terms num and den, the hit candidate test, dir * num and
// the magnitudes and overflow check that set up the divider.
// ----------------------------------------------------------------------------
module rqi_plane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_vld_i,
  input  logic [6*rqi_pkg::CW-1:0] in_data_i,
  input  rqi_pkg::geom_t           geom_i,
  output logic                     out_vld_o,
  output rqi_pkg::div_t            out_o
);
  import rqi_pkg::*;

  logic                  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [CW-1:0]  org0_q [3];
  logic signed [CW-1:0]  dir0_q [3];
  logic signed [CW-1:0]  org1_q [3];
  logic signed [CW-1:0]  dir1_q [3];
  logic signed [PNW-1:0] pn1_q [3];
  logic signed [PDW-1:0] pd1_q [3];
  logic signed [CW-1:0]  org2_q [3];
  logic signed [CW-1:0]  dir2_q [3];
  logic signed [NUMW-1:0] num2_q;
  logic signed [DENW-1:0] den2_q;
  logic signed [CW-1:0]  org3_q [3];
  logic                  cand3_q;
  logic signed [DENW-1:0] den3_q;
  logic signed [PRW-1:0] prod3_q [3];
  logic signed [CW-1:0]  org4_q [3];
  logic                  cand4_q;
  logic [DENW-1:0]       aden4_q;
  logic [PRW-1:0]        aprod4_q [3];
  logic [2:0]            neg4_q;
  rqi_pkg::div_t         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q} <= '0;
    end else if (en_i) begin
      {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q} <= {in_vld_i, v0_q, v1_q, v2_q, v3_q, v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        org0_q[k] <= $signed(in_data_i[k*CW +: CW]);
        dir0_q[k] <= $signed(in_data_i[(k+3)*CW +: CW]);
        org1_q[k] <= org0_q[k];
        dir1_q[k] <= dir0_q[k];
        pn1_q[k]  <= PNW'($signed(geom_i.nrm[k]))
                     * PNW'(cdiff(geom_i.vtx[0][k], org0_q[k]));
        pd1_q[k]  <= PDW'($signed(geom_i.nrm[k])) * PDW'(dir0_q[k]);
        org2_q[k] <= org1_q[k];
        dir2_q[k] <= dir1_q[k];
        org3_q[k] <= org2_q[k];
        prod3_q[k] <= PRW'(dir2_q[k]) * PRW'(num2_q);
        org4_q[k]  <= org3_q[k];
        aprod4_q[k] <= prod3_q[k][PRW-1] ? PRW'(-prod3_q[k]) : PRW'(prod3_q[k]);
        neg4_q[k]   <= prod3_q[k][PRW-1] ^ den3_q[DENW-1];
        out_q.org[k] <= org4_q[k];
        out_q.ovf[k] <= (PRW+1)'(aprod4_q[k]) >= ((PRW+1)'(aden4_q) << QW);
        out_q.rem[k] <= DENW'(aprod4_q[k] >> QW);
        out_q.low[k] <= aprod4_q[k][QW-1:0];
        out_q.quo[k] <= '0;
      end
      num2_q  <= NUMW'(pn1_q[0]) + NUMW'(pn1_q[1]) + NUMW'(pn1_q[2]);
      den2_q  <= DENW'(pd1_q[0]) + DENW'(pd1_q[1]) + DENW'(pd1_q[2]);
      // a candidate needs den nonzero and t >= 0: num and den of one sign, or num zero
      cand3_q <= (den2_q != '0)
                 && ((num2_q == '0) || (num2_q[NUMW-1] == den2_q[DENW-1]));
      den3_q  <= den2_q;
      cand4_q <= cand3_q;
      aden4_q <= den3_q[DENW-1] ? DENW'(-den3_q) : DENW'(den3_q);
      out_q.cand <= cand4_q;
      out_q.den  <= aden4_q;
      out_q.neg  <= neg4_q;
    end
  end

  assign out_vld_o = v5_q;
  assign out_o     = out_q;

endmodule

### hw/rtl/rqi_div.sv
// ----------------------------------------------------------------------------
// rqi_div
// Pipelined restoring divider, one quotient bit per stage for all three
// coordinates; the high part of the dividend is already below the divisor.
// ----------------------------------------------------------------------------
module rqi_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_vld_i,
  input  rqi_pkg::div_t in_i,
  output logic          out_vld_o,
  output rqi_pkg::div_t out_o
);
  import rqi_pkg::*;

  logic [QW-1:0] vld_q;
  div_t          cur   [QW];
  div_t          stg_d [QW];
  div_t          stg_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int BIT = QW - 1 - j;

    if (j == 0) begin : g_first
      assign cur[j] = in_i;
    end else begin : g_next
      assign cur[j] = stg_q[j-1];
    end

    always_comb begin
      logic [DENW:0] remx;
      logic          ge;
      stg_d[j] = cur[j];
      for (int k = 0; k < 3; k++) begin
        remx = {cur[j].rem[k], cur[j].low[k][BIT]};
        ge   = remx >= {1'b0, cur[j].den};
        stg_d[j].rem[k]      = ge ? DENW'(remx - {1'b0, cur[j].den}) : DENW'(remx);
        stg_d[j].quo[k][BIT] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= (j == 0) ? in_vld_i : vld_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  assign out_vld_o = vld_q[QW-1];
  assign out_o     = stg_q[QW-1];

endmodule

### hw/rtl/rqi_bary.sv
// ----------------------------------------------------------------------------
// rqi_bary
// Saturates the intersection point, then runs the six projected barycentric
// side tests of the two triangles and forms the registered result.
// ----------------------------------------------------------------------------
module rqi_bary (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_vld_i,
  input  rqi_pkg::div_t            in_i,
  input  rqi_pkg::geom_t           geom_i,
  output logic                     out_vld_o,
  output logic                     out_hit_o,
  output logic [3*rqi_pkg::CW-1:0] out_pt_o
);
  import rqi_pkg::*;

  logic [5:0]            vld_q;
  logic signed [CW-1:0]  pt_d [3];
  logic signed [CW-1:0]  p0_q [3];
  logic signed [CW-1:0]  p1_q [3];
  logic signed [CW-1:0]  p2_q [3];
  logic signed [CW-1:0]  p3_q [3];
  logic signed [CW-1:0]  p4_q [3];
  logic [4:0]            cand_q;
  logic signed [PW-1:0]  erp_q [NSIDE][3];
  logic signed [PW-1:0]  frp_q [NSIDE][3];
  logic signed [DTW-1:0] er_q [NSIDE];
  logic signed [DTW-1:0] fr_q [NSIDE];
  logic signed [BW-1:0]  m1_q [NSIDE];
  logic signed [BW-1:0]  m2_q [NSIDE];
  logic signed [BW-1:0]  nn   [NSIDE];
  logic [NSIDE-1:0]      ok_d;
  logic [NSIDE-1:0]      ok_q;
  logic                  hit_q;
  logic [3*CW-1:0]       pt_q;

  always_comb begin
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      qs  = $signed(SW'(in_i.quo[k]));
      sum = SW'($signed(in_i.org[k])) + (in_i.neg[k] ? -qs : qs);
      priority if (in_i.ovf[k]) begin
        pt_d[k] = in_i.neg[k] ? CMIN : CMAX;
      end else if (sum > SW'(CMAX)) begin
        pt_d[k] = CMAX;
      end else if (sum < SW'(CMIN)) begin
        pt_d[k] = CMIN;
      end else begin
        pt_d[k] = CW'(sum);
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NSIDE; s++) begin
      nn[s]   = m1_q[s] - m2_q[s];
      ok_d[s] = ($signed(geom_i.dd[s]) > 0) && (nn[s] >= 0)
                && (nn[s] <= $signed(geom_i.dd[s]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_q <= {cand_q[3:0], in_i.cand};
      for (int k = 0; k < 3; k++) begin
        p0_q[k] <= pt_d[k];
        p1_q[k] <= p0_q[k];
        p2_q[k] <= p1_q[k];
        p3_q[k] <= p2_q[k];
        p4_q[k] <= p3_q[k];
      end
      for (int s = 0; s < NSIDE; s++) begin
        for (int k = 0; k < 3; k++) begin
          erp_q[s][k] <= PW'($signed(geom_i.ev[s][k]))
                         * PW'(cdiff(p0_q[k], geom_i.vtx[SIDE_RB[s]][k]));
          frp_q[s][k] <= PW'($signed(geom_i.fv[s][k]))
                         * PW'(cdiff(p0_q[k], geom_i.vtx[SIDE_RB[s]][k]));
        end
        er_q[s] <= DTW'(erp_q[s][0]) + DTW'(erp_q[s][1]) + DTW'(erp_q[s][2]);
        fr_q[s] <= DTW'(frp_q[s][0]) + DTW'(frp_q[s][1]) + DTW'(frp_q[s][2]);
        m1_q[s] <= BW'(er_q[s]) * BW'($signed(geom_i.ff[s]));
        m2_q[s] <= BW'($signed(geom_i.ef[s])) * BW'(fr_q[s]);
      end
      ok_q  <= ok_d;
      // zero the point on a miss
      hit_q <= cand_q[4] && ((&ok_q[2:0]) || (&ok_q[5:3]));
      for (int k = 0; k < 3; k++) begin
        pt_q[k*CW +: CW] <= (cand_q[4] && ((&ok_q[2:0]) || (&ok_q[5:3])))
                            ? p4_q[k] : '0;
      end
    end
  end

  assign out_vld_o = vld_q[5];
  assign out_hit_o = hit_q;
  assign out_pt_o  = pt_q;

endmodule

### hw/rtl/ray_quad_intersect.sv
// ----------------------------------------------------------------------------
// ray_quad_intersect
// Ray against a fixed quad: hit flag and saturated intersection point.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
//  m_axis    out        tdata: hit_x, hit_y, hit_z; tuser: hit
//  cfg       in         vertex_zero .. vertex_three, one per index
//
//  One transaction per cycle in while the output is not stalled;
//  6 plane stages, 17 divider stages, 6 point and side-test stages.
//  The 17-stage restoring divider sets the depth.
//  Reset clears the corners to zero and empties the pipeline.
//  A stalled output freezes the whole pipeline; nothing is dropped.
//  After a write, corner geometry settles through the cfg derivation registers.
// ----------------------------------------------------------------------------
module ray_quad_intersect (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [6*rqi_pkg::CW-1:0] s_axis_tdata,  // origin x,y,z then dir x,y,z
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [3*rqi_pkg::CW-1:0] m_axis_tdata,  // hit_x, hit_y, hit_z
  output logic                     m_axis_tuser,  // hit
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [rqi_pkg::VW-1:0]   cfg_data_i
);
  import rqi_pkg::*;

  geom_t geom;
  div_t  plane_out;
  div_t  div_out;
  logic  plane_vld;
  logic  div_vld;
  logic  en;

  // advance unless a finished transaction is held at the output
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rqi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  rqi_plane u_plane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (s_axis_tvalid),
    .in_data_i (s_axis_tdata),
    .geom_i    (geom),
    .out_vld_o (plane_vld),
    .out_o     (plane_out)
  );

  rqi_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (plane_vld),
    .in_i      (plane_out),
    .out_vld_o (div_vld),
    .out_o     (div_out)
  );

  rqi_bary u_bary (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (div_vld),
    .in_i      (div_out),
    .geom_i    (geom),
    .out_vld_o (m_axis_tvalid),
    .out_hit_o (m_axis_tuser),
    .out_pt_o  (m_axis_tdata)
  );

endmodule

### hw/rtl/rqi_checker.sv
// ----------------------------------------------------------------------------
// rqi_props
// Port-level checks on the output channel and backpressure, bound to the
// top level.
// ----------------------------------------------------------------------------
module rqi_props (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [3*rqi_pkg::CW-1:0] m_axis_tdata,
  input logic                     m_axis_tuser
);

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss transaction carries a nonzero point");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output is stalled");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped during stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed during stall");

endmodule

bind ray_quad_intersect rqi_props u_rqi_props (.*);
